FILE: rtl/aoc_pkg.sv
// ----------------------------------------------------------------------------
// aoc_pkg
// Shared codes, constants and channel blend function for the alpha-over-
// checkerboard compositor.
// ----------------------------------------------------------------------------
package aoc_pkg;

  // Pixel mode codes
  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_BGRA  = 2'd1;
  localparam logic [1:0] MODE_IDX8  = 2'd2;
  localparam logic [1:0] MODE_IDX4  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_PIXEL_MODE  = 2'd0;
  localparam logic [1:0] REG_ROW_LENGTH  = 2'd1;
  localparam logic [1:0] REG_TRANS_INDEX = 2'd2;

  // Checker shades and background palette index
  localparam logic [7:0] SHADE_A  = 8'hc0;
  localparam logic [7:0] SHADE_B  = 8'he0;
  localparam logic [7:0] BG_INDEX = 8'd2;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // Register reset values
  localparam logic [1:0]  PIXEL_MODE_RST  = MODE_BGRA;
  localparam logic [15:0] ROW_LENGTH_RST  = 16'd64;
  localparam logic [7:0]  TRANS_INDEX_RST = 8'd0;

  // Blend one channel over a background shade: (c*a + bg*(256-a)) >> 8
  function automatic logic [7:0] blend_channel(input logic [7:0] c,
                                               input logic [7:0] a,
                                               input logic [7:0] bg);
    logic [17:0] sum;
    sum = 18'(c) * 18'(a) + 18'(bg) * (18'd256 - 18'(a));
    return sum[15:8];
  endfunction

endpackage

FILE: rtl/alpha_over_checkerboard.sv
// ----------------------------------------------------------------------------
// alpha_over_checkerboard
// Composites a pixel stream over a checkerboard, one word a cycle if unstalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_axis channel: tdata carries the pixel (BGRA,
//   B in the low byte; indexed modes use the low byte), tuser flags the first
//   unit of a frame and restarts the checker counters before that unit.
//   Results leave on m_axis: tdata carries the composited pixel or index byte.
//   The cfg port writes pixel_mode, row_length and trans_index; write it only
//   while no word is in flight.
//   The result is registered and becomes valid in the cycle after the input is
//   accepted. Throughput is one word per cycle while the receiver does not
//   stall: the checker state update and the three channel blends sit between
//   the checker state and the output register.
//   When the receiver stalls, the output register holds its word and
//   s_axis_tready drops only while that register is full and not drained in
//   the same cycle.
//   Reset empties the output register, restores the register defaults (BGRA
//   mode, 64-unit rows, index 0 transparent) and rewinds the checkerboard.
// ----------------------------------------------------------------------------
module alpha_over_checkerboard #(
  parameter int TILE_SIZE = 6,
  parameter int ROW_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] pixel_in
  input  logic        s_axis_tuser,   // [0] start_of_frame
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] pixel_out
);

  localparam int TW      = $clog2(TILE_SIZE + 1);
  localparam int RW      = $clog2(TILE_SIZE);
  localparam int CW      = ROW_BITS + 1;
  localparam int CMPW    = (ROW_BITS + 2 > 17) ? ROW_BITS + 2 : 17;
  localparam logic [TW-1:0] TILE_FULL = TW'(TILE_SIZE);
  localparam logic [TW-1:0] TILE_HALF = TW'(TILE_SIZE / 2);

  // Configuration registers
  logic [1:0]  pixel_mode_q;
  logic [15:0] row_length_q;
  logic [7:0]  trans_index_q;

  // Checker state
  logic [TW-1:0]       tile_left_q, tile_left_d;
  logic [ROW_BITS-1:0] column_count_q, column_count_d;
  logic [RW-1:0]       row_in_band_q, row_in_band_d;
  logic                tile_phase_q, tile_phase_d;
  logic                band_phase_q, band_phase_d;

  // Output register
  logic        out_valid_q;
  logic [31:0] out_data_q, out_data_d;

  logic          accept;
  logic [TW-1:0] tile_w;

  // Checker state after an optional frame restart
  logic [TW-1:0]       eff_left;
  logic [ROW_BITS-1:0] eff_col;
  logic [RW-1:0]       eff_rib;
  logic                eff_tphase;
  logic                eff_bphase;

  logic [CW-1:0]   col_sum;
  logic [CMPW-1:0] col_ext, row_ext, reach;
  logic [RW:0]     rib_inc;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign tile_w        = (pixel_mode_q == aoc_pkg::MODE_IDX4) ? TILE_HALF : TILE_FULL;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_mode_q  <= aoc_pkg::PIXEL_MODE_RST;
      row_length_q  <= aoc_pkg::ROW_LENGTH_RST;
      trans_index_q <= aoc_pkg::TRANS_INDEX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aoc_pkg::REG_PIXEL_MODE:  pixel_mode_q  <= cfg_data_i[1:0];
        aoc_pkg::REG_ROW_LENGTH:  row_length_q  <= cfg_data_i;
        aoc_pkg::REG_TRANS_INDEX: trans_index_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Restart the checkerboard at frame start
  always_comb begin
    if (s_axis_tuser) begin
      eff_left   = tile_w;
      eff_col    = '0;
      eff_rib    = '0;
      eff_tphase = 1'b0;
      eff_bphase = 1'b0;
    end else begin
      eff_left   = tile_left_q;
      eff_col    = column_count_q;
      eff_rib    = row_in_band_q;
      eff_tphase = tile_phase_q;
      eff_bphase = band_phase_q;
    end
  end

  // Advance the checkerboard by one unit (held in pass mode)
  always_comb begin
    tile_left_d    = eff_left;
    column_count_d = eff_col;
    row_in_band_d  = eff_rib;
    tile_phase_d   = eff_tphase;
    band_phase_d   = eff_bphase;
    col_sum        = CW'(eff_col) + CW'(tile_w);
    col_ext        = CMPW'(col_sum);
    row_ext        = CMPW'(row_length_q);
    reach          = col_ext + CMPW'(tile_w);
    rib_inc        = (RW+1)'(eff_rib) + (RW+1)'(1);
    if (pixel_mode_q != aoc_pkg::MODE_PASS) begin
      if (eff_left > TW'(1)) begin
        tile_left_d = eff_left - TW'(1);
      end else begin
        tile_phase_d   = ~eff_tphase;
        tile_left_d    = tile_w;
        column_count_d = col_sum[ROW_BITS-1:0];
        if (reach >= row_ext) begin
          if (col_ext < row_ext) begin
            // Shorten the last tile of the row
            tile_left_d = TW'(row_ext - col_ext);
          end else begin
            // Wrap to the next row
            column_count_d = '0;
            if (rib_inc >= (RW+1)'(TILE_SIZE)) begin
              row_in_band_d = '0;
              band_phase_d  = ~eff_bphase;
            end else begin
              row_in_band_d = rib_inc[RW-1:0];
            end
            tile_phase_d = (rib_inc >= (RW+1)'(TILE_SIZE)) ? ~eff_bphase : eff_bphase;
          end
        end
      end
    end
  end

  // Composite the current word
  always_comb begin
    logic [7:0] px_a;
    logic [7:0] bg;
    logic [7:0] bg_idx;
    logic [3:0] lo;
    logic [3:0] hi;
    px_a   = s_axis_tdata[31:24];
    bg     = eff_tphase ? aoc_pkg::SHADE_B : aoc_pkg::SHADE_A;
    bg_idx = aoc_pkg::BG_INDEX | {7'd0, eff_tphase};
    lo     = s_axis_tdata[3:0];
    hi     = s_axis_tdata[7:4];
    case (pixel_mode_q)
      aoc_pkg::MODE_PASS: begin
        out_data_d = s_axis_tdata;
      end
      aoc_pkg::MODE_BGRA: begin
        if (px_a != aoc_pkg::ALPHA_OPAQUE) begin
          out_data_d = {aoc_pkg::ALPHA_OPAQUE,
                        aoc_pkg::blend_channel(s_axis_tdata[23:16], px_a, bg),
                        aoc_pkg::blend_channel(s_axis_tdata[15:8], px_a, bg),
                        aoc_pkg::blend_channel(s_axis_tdata[7:0], px_a, bg)};
        end else begin
          out_data_d = s_axis_tdata;
        end
      end
      aoc_pkg::MODE_IDX8: begin
        out_data_d = {24'd0, (s_axis_tdata[7:0] == trans_index_q) ? bg_idx
                                                                  : s_axis_tdata[7:0]};
      end
      default: begin
        if (lo == trans_index_q[3:0]) lo = bg_idx[3:0];
        if (hi == trans_index_q[3:0]) hi = bg_idx[3:0];
        out_data_d = {24'd0, hi, lo};
      end
    endcase
  end

  // Update checker state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_left_q    <= TILE_FULL;
      column_count_q <= '0;
      row_in_band_q  <= '0;
      tile_phase_q   <= 1'b0;
      band_phase_q   <= 1'b0;
    end else if (accept) begin
      tile_left_q    <= tile_left_d;
      column_count_q <= column_count_d;
      row_in_band_q  <= row_in_band_d;
      tile_phase_q   <= tile_phase_d;
      band_phase_q   <= band_phase_d;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

endmodule
